// ===== rtl/mavp_pkg.sv =====
// ----------------------------------------------------------------------------
// mavp_pkg
// Shared widths, types and helpers for the moving average peak filter.
// ----------------------------------------------------------------------------
package mavp_pkg;

  // sizing
  localparam int MAX_WINDOW   = 1024;
  localparam int SAMPLE_BITS  = 16;
  localparam int CFG_BITS     = 11;
  localparam int RESET_LENGTH = 16;
  localparam int PTR_BITS     = $clog2(MAX_WINDOW);
  localparam int EFF_BITS     = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS     = SAMPLE_BITS + PTR_BITS;
  localparam int QUO_BITS     = SAMPLE_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic [EFF_BITS-1:0]           len_t;
  typedef logic [PTR_BITS-1:0]           ptr_t;
  typedef logic [CFG_BITS-1:0]           cfg_t;

  // one stage of the divider row, handed from cell to cell
  typedef struct packed {
    logic                valid;
    logic                neg;
    len_t                divisor;
    len_t                rem;
    logic [QUO_BITS-1:0] dvd;
    logic [QUO_BITS-1:0] quo;
  } div_stage_t;

  // zero acts as one, anything above the store depth saturates
  function automatic len_t eff_length(cfg_t w);
    if (w == '0) begin
      return len_t'(1);
    end else if (32'(w) > 32'(MAX_WINDOW)) begin
      return len_t'(MAX_WINDOW);
    end else begin
      return len_t'(w);
    end
  endfunction

endpackage

// ===== rtl/mavp_div_cell.sv =====
// ----------------------------------------------------------------------------
// mavp_div_cell
// One restoring division step: develops one quotient bit and registers it.
// ----------------------------------------------------------------------------
module mavp_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  mavp_pkg::div_stage_t stage_in,
  output mavp_pkg::div_stage_t stage_out
);

  logic [mavp_pkg::EFF_BITS:0] trial;
  logic [mavp_pkg::EFF_BITS:0] dsor_ext;
  logic                        fits;
  mavp_pkg::div_stage_t        stage_nxt;
  mavp_pkg::div_stage_t        payload_r;
  logic                        valid_r;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial     = {stage_in.rem, stage_in.dvd[mavp_pkg::QUO_BITS-1]};
    dsor_ext  = {1'b0, stage_in.divisor};
    fits      = (trial >= dsor_ext);
    stage_nxt = stage_in;
    stage_nxt.rem = fits ? mavp_pkg::EFF_BITS'(trial - dsor_ext)
                         : mavp_pkg::EFF_BITS'(trial);
    stage_nxt.dvd = stage_in.dvd << 1;
    stage_nxt.quo = {stage_in.quo[mavp_pkg::QUO_BITS-2:0], fits};
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= stage_in.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    payload_r <= stage_nxt;
  end

  always_comb begin
    stage_out       = payload_r;
    stage_out.valid = valid_r;
  end

endmodule

// ===== rtl/mavp_div_row.sv =====
// ----------------------------------------------------------------------------
// mavp_div_row
// Row of division cells, one per quotient bit, each feeding its neighbor.
// ----------------------------------------------------------------------------
module mavp_div_row (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mavp_pkg::div_stage_t stage_in,
  output mavp_pkg::div_stage_t stage_out
);

  mavp_pkg::div_stage_t link [mavp_pkg::QUO_BITS+1];

  assign link[0] = stage_in;

  // cell k settles quotient bit QUO_BITS-1-k
  for (genvar k = 0; k < mavp_pkg::QUO_BITS; k++) begin : g_cell
    mavp_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_in  (link[k]),
      .stage_out (link[k+1])
    );
  end

  assign stage_out = link[mavp_pkg::QUO_BITS];

endmodule

// ===== rtl/moving_average_peak.sv =====
// ----------------------------------------------------------------------------
// moving_average_peak
// Moving average over a programmable window with peak average tracking.
// ----------------------------------------------------------------------------
// Takes one sample item at a time, and the oldest sample is read from the
// window memory at the accepting edge itself. A sample that still fills the
// window passes through the update state and back to idle before the next
// item can be accepted, and gives no result. A sample that completes a
// window updates the running sum while the first division cell takes its
// step, passes through the rest of the row of restoring division cells,
// has its average and peak captured, loads the result register, and
// returns to idle. A result can only be loaded once the previous one has
// been taken, so a stalled output delays the load. The result register
// decouples the two sides: a new item is accepted while an earlier result
// still waits. The input stalls during a window_length write, and the
// write restarts the window; the window memory needs no clearing pass.
module moving_average_peak (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [mavp_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [mavp_pkg::SAMPLE_BITS-1:0] out_average,
  output logic signed [mavp_pkg::SAMPLE_BITS-1:0] out_peak_average,
  input  logic                          cfg_wr_en,
  input  logic [mavp_pkg::CFG_BITS-1:0] cfg_wr_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_UPDATE = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  localparam int AW = mavp_pkg::EFF_BITS + 1;
  localparam int SW = mavp_pkg::SAMPLE_BITS;

  logic [1:0]             state_r;
  mavp_pkg::cfg_t         window_length_r;
  mavp_pkg::sum_t         sum_r;
  mavp_pkg::len_t         fill_cnt_r;
  mavp_pkg::ptr_t         ptr_r;
  mavp_pkg::sample_t      peak_r;
  logic                   full_r;
  mavp_pkg::sample_t      sample_r;
  mavp_pkg::sample_t      old_r;
  mavp_pkg::sample_t      avg_r;
  logic                   out_valid_r;
  mavp_pkg::sample_t      out_average_r;
  mavp_pkg::sample_t      out_peak_r;

  mavp_pkg::sample_t      win_mem [mavp_pkg::MAX_WINDOW];

  mavp_pkg::len_t         eff_len;
  logic                   in_accept;
  logic                   out_free;
  mavp_pkg::len_t         cnt_base;
  mavp_pkg::ptr_t         ptr_base;
  logic [AW-1:0]          ptr_ext;
  logic [AW-1:0]          len_ext;
  mavp_pkg::ptr_t         old_addr;
  mavp_pkg::sum_t         sum_upd;
  mavp_pkg::len_t         cnt_upd;
  mavp_pkg::ptr_t         ptr_upd;
  logic                   launch;
  logic [mavp_pkg::SUM_BITS-1:0] sum_mag;
  mavp_pkg::div_stage_t   div_in;
  mavp_pkg::div_stage_t   div_out;
  logic [mavp_pkg::QUO_BITS:0] quo_ext;
  logic [mavp_pkg::QUO_BITS:0] avg_full;
  mavp_pkg::sample_t      avg_val;
  logic signed [SW:0]     peak_ext;
  logic [SW:0]            peak_mag;
  mavp_pkg::sample_t      peak_nxt;

  // handshake
  assign eff_len   = mavp_pkg::eff_length(window_length_r);
  assign in_stall  = (state_r != ST_IDLE) || cfg_wr_en;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // oldest sample address, with restart applied first
  always_comb begin
    cnt_base = in_restart ? '0 : fill_cnt_r;
    ptr_base = in_restart ? '0 : ptr_r;
    ptr_ext  = AW'(ptr_base);
    len_ext  = AW'(eff_len);
    if (ptr_ext >= len_ext) begin
      old_addr = mavp_pkg::PTR_BITS'(ptr_ext - len_ext);
    end else begin
      old_addr = mavp_pkg::PTR_BITS'(ptr_ext + AW'(mavp_pkg::MAX_WINDOW) - len_ext);
    end
  end

  // running sum, fill count and pointer update
  always_comb begin
    sum_upd = sum_r - (full_r ? mavp_pkg::sum_t'(old_r) : '0)
            + mavp_pkg::sum_t'(sample_r);
    cnt_upd = full_r ? fill_cnt_r : fill_cnt_r + mavp_pkg::len_t'(1);
    ptr_upd = (ptr_r == mavp_pkg::PTR_BITS'(mavp_pkg::MAX_WINDOW - 1)) ? '0
                                                  : ptr_r + mavp_pkg::ptr_t'(1);
    launch  = (state_r == ST_UPDATE) && (cnt_upd == eff_len);
  end

  // divider feed: magnitude split into a high remainder and low dividend bits
  always_comb begin
    sum_mag        = sum_upd[mavp_pkg::SUM_BITS-1] ? mavp_pkg::SUM_BITS'(-sum_upd)
                                                   : mavp_pkg::SUM_BITS'(sum_upd);
    div_in.valid   = launch;
    div_in.neg     = sum_upd[mavp_pkg::SUM_BITS-1];
    div_in.divisor = eff_len;
    div_in.rem     = mavp_pkg::EFF_BITS'(sum_mag[mavp_pkg::SUM_BITS-1:mavp_pkg::QUO_BITS]);
    div_in.dvd     = sum_mag[mavp_pkg::QUO_BITS-1:0];
    div_in.quo     = '0;
  end

  mavp_div_row u_div_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage_in  (div_in),
    .stage_out (div_out)
  );

  // signed average and peak selection, newer wins ties
  always_comb begin
    quo_ext  = {1'b0, div_out.quo};
    avg_full = div_out.neg ? -quo_ext : quo_ext;
    avg_val  = avg_full[SW-1:0];
    peak_ext = (SW+1)'(peak_r);
    peak_mag = peak_ext[SW] ? (SW+1)'(-peak_ext) : (SW+1)'(peak_ext);
    peak_nxt = (quo_ext >= peak_mag) ? avg_val : peak_r;
  end

  // sequencer and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      window_length_r <= mavp_pkg::CFG_BITS'(mavp_pkg::RESET_LENGTH);
      sum_r           <= '0;
      fill_cnt_r      <= '0;
      ptr_r           <= '0;
      peak_r          <= '0;
      full_r          <= 1'b0;
    end else if (cfg_wr_en) begin
      // a length write restarts the window
      window_length_r <= cfg_wr_data;
      sum_r           <= '0;
      fill_cnt_r      <= '0;
      ptr_r           <= '0;
      peak_r          <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_restart) begin
              sum_r      <= '0;
              fill_cnt_r <= '0;
              ptr_r      <= '0;
              peak_r     <= '0;
            end
            full_r  <= (cnt_base >= eff_len);
            state_r <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          sum_r      <= sum_upd;
          fill_cnt_r <= cnt_upd;
          ptr_r      <= ptr_upd;
          state_r    <= launch ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          if (div_out.valid) begin
            peak_r  <= peak_nxt;
            state_r <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // result valid: set when a result is loaded, held while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_RESULT && out_free) || (out_valid_r && out_stall);
    end
  end

  // window memory: write the new sample, read the oldest one
  always_ff @(posedge clk) begin
    if (state_r == ST_UPDATE) begin
      win_mem[ptr_r] <= sample_r;
    end
    if (in_accept) begin
      old_r <= win_mem[old_addr];
    end
  end

  // item payload and result register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_r <= in_sample;
    end
    if (state_r == ST_DIV && div_out.valid) begin
      avg_r <= avg_val;
    end
    if (state_r == ST_RESULT && out_free) begin
      out_average_r <= avg_r;
      out_peak_r    <= peak_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_average      = out_average_r;
  assign out_peak_average = out_peak_r;

  // checks
  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_out.valid |-> state_r == ST_DIV)
    else $error("division result outside the divide state");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r <= eff_len)
    else $error("fill count above window length");

  a_peak_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE || state_r == ST_RESULT) && !cfg_wr_en |=> $stable(peak_r))
    else $error("peak changed outside the divide state");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RESULT && out_free && !cfg_wr_en |=> out_valid_r && state_r == ST_IDLE)
    else $error("result not loaded when the output was free");

endmodule
